// ===== design/tksd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_pkg: terminal key sequence decoder package
// Parse modes, key codes and the plain-byte key table shared by the decoder.
// ----------------------------------------------------------------------------
package tksd_pkg;

	typedef logic [5:0] key_t;

	typedef enum logic [5:0] {
		MODE_IDLE    = 6'b000001,
		MODE_ESC     = 6'b000010,
		MODE_ESC_O   = 6'b000100,
		MODE_ESC_BR  = 6'b001000,
		MODE_ESC_BR1 = 6'b010000,
		MODE_SKIP    = 6'b100000
	} mode_t;

	typedef struct packed {
		logic  emit;
		key_t  key;
		mode_t mode;
		key_t  held;
	} step_t;

	localparam key_t K_UNKNOWN  = 6'd0;
	localparam key_t K_ENTER    = 6'd1;
	localparam key_t K_SPACE    = 6'd2;
	localparam key_t K_TAB      = 6'd3;
	localparam key_t K_COMMA    = 6'd4;
	localparam key_t K_PERIOD   = 6'd5;
	localparam key_t K_BACK     = 6'd6;
	localparam key_t K_DELETE   = 6'd7;
	localparam key_t K_ESC      = 6'd8;
	localparam key_t K_HOME     = 6'd9;
	localparam key_t K_END      = 6'd10;
	localparam key_t K_F1       = 6'd11;
	localparam key_t K_INSERT   = 6'd15;
	localparam key_t K_PGUP     = 6'd16;
	localparam key_t K_PGDN     = 6'd17;
	localparam key_t K_UP       = 6'd18;
	localparam key_t K_F5       = 6'd22;
	localparam key_t K_DIGIT0   = 6'd26;
	localparam key_t K_LETTER_A = 6'd36;

	localparam logic [7:0] B_TAB    = 8'd9;
	localparam logic [7:0] B_LF     = 8'd10;
	localparam logic [7:0] B_ESC    = 8'd27;
	localparam logic [7:0] B_SPACE  = 8'd32;
	localparam logic [7:0] B_COMMA  = 8'd44;
	localparam logic [7:0] B_PERIOD = 8'd46;
	localparam logic [7:0] B_ZERO   = 8'd48;
	localparam logic [7:0] B_ONE    = 8'd49;
	localparam logic [7:0] B_TWO    = 8'd50;
	localparam logic [7:0] B_THREE  = 8'd51;
	localparam logic [7:0] B_FIVE   = 8'd53;
	localparam logic [7:0] B_SIX    = 8'd54;
	localparam logic [7:0] B_SEVEN  = 8'd55;
	localparam logic [7:0] B_NINE   = 8'd57;
	localparam logic [7:0] B_UC_A   = 8'd65;
	localparam logic [7:0] B_UC_D   = 8'd68;
	localparam logic [7:0] B_UC_F   = 8'd70;
	localparam logic [7:0] B_UC_H   = 8'd72;
	localparam logic [7:0] B_UC_O   = 8'd79;
	localparam logic [7:0] B_UC_P   = 8'd80;
	localparam logic [7:0] B_UC_S   = 8'd83;
	localparam logic [7:0] B_UC_Z   = 8'd90;
	localparam logic [7:0] B_LBRACK = 8'd91;
	localparam logic [7:0] B_LC_A   = 8'd97;
	localparam logic [7:0] B_LC_Z   = 8'd122;
	localparam logic [7:0] B_TILDE  = 8'd126;
	localparam logic [7:0] B_DEL    = 8'd127;

	function automatic key_t offset_key(input key_t base, input logic [7:0] b,
			input logic [7:0] first);
		logic [7:0] diff;
		diff = b - first;
		return base + diff[5:0];
	endfunction

	function automatic key_t plain_key(input logic [7:0] b);
		key_t k;
		k = K_UNKNOWN;
		priority if (b == B_LF) k = K_ENTER;
		else if (b == B_SPACE) k = K_SPACE;
		else if (b == B_TAB) k = K_TAB;
		else if (b == B_COMMA) k = K_COMMA;
		else if (b == B_PERIOD) k = K_PERIOD;
		else if (b == B_DEL) k = K_BACK;
		else if (b == B_TILDE) k = K_DELETE;
		else if (b >= B_ZERO && b <= B_NINE) k = offset_key(K_DIGIT0, b, B_ZERO);
		else if (b >= B_UC_A && b <= B_UC_Z) k = offset_key(K_LETTER_A, b, B_UC_A);
		else if (b >= B_LC_A && b <= B_LC_Z) k = offset_key(K_LETTER_A, b, B_LC_A);
		else k = K_UNKNOWN;
		return k;
	endfunction

endpackage
`default_nettype wire

// ===== design/tksd_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tksd_decode: one parse step
// Maps the current parse mode, held key and one byte to the next mode, the
// next held key and an optional key code.
// ----------------------------------------------------------------------------
module tksd_decode import tksd_pkg::*; (
	input  wire mode_t       mode,
	input  wire key_t        held,
	input  wire logic [7:0]  byte_in,
	input  wire logic        more_pending,
	output step_t            step
);

	always_comb begin
		step.emit = 1'b1;
		step.key  = K_UNKNOWN;
		step.mode = MODE_IDLE;
		step.held = held;
		unique case (mode)
			MODE_ESC: begin
				if (byte_in == B_UC_O) begin
					step.emit = 1'b0;
					step.mode = MODE_ESC_O;
				end else if (byte_in == B_LBRACK) begin
					step.emit = 1'b0;
					step.mode = MODE_ESC_BR;
				end
			end
			MODE_ESC_O: begin
				priority if (byte_in == B_UC_H) step.key = K_HOME;
				else if (byte_in == B_UC_F) step.key = K_END;
				else if (byte_in >= B_UC_P && byte_in <= B_UC_S)
					step.key = offset_key(K_F1, byte_in, B_UC_P);
				else step.key = K_UNKNOWN;
			end
			MODE_ESC_BR: begin
				priority if (byte_in == B_TWO) begin
					step.emit = 1'b0;
					step.held = K_INSERT;
					step.mode = MODE_SKIP;
				end else if (byte_in == B_THREE) begin
					step.emit = 1'b0;
					step.held = K_DELETE;
					step.mode = MODE_SKIP;
				end else if (byte_in == B_FIVE) begin
					step.emit = 1'b0;
					step.held = K_PGUP;
					step.mode = MODE_SKIP;
				end else if (byte_in == B_SIX) begin
					step.emit = 1'b0;
					step.held = K_PGDN;
					step.mode = MODE_SKIP;
				end else if (byte_in == B_ONE) begin
					step.emit = 1'b0;
					step.mode = MODE_ESC_BR1;
				end else if (byte_in >= B_UC_A && byte_in <= B_UC_D) begin
					step.key = offset_key(K_UP, byte_in, B_UC_A);
				end else begin
					step.key = K_UNKNOWN;
				end
			end
			MODE_ESC_BR1: begin
				if (byte_in == B_FIVE) begin
					step.emit = 1'b0;
					step.held = K_F5;
					step.mode = MODE_SKIP;
				end else if (byte_in >= B_SEVEN && byte_in <= B_NINE) begin
					step.emit = 1'b0;
					step.held = offset_key(K_F5 + 6'd1, byte_in, B_SEVEN);
					step.mode = MODE_SKIP;
				end
			end
			MODE_SKIP: begin
				step.key = held;
			end
			default: begin
				if (byte_in == B_ESC) begin
					if (more_pending) begin
						step.emit = 1'b0;
						step.mode = MODE_ESC;
					end else begin
						step.key = K_ESC;
					end
				end else begin
					step.key = plain_key(byte_in);
				end
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== design/terminal_key_sequence_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// terminal_key_sequence_decoder: VT100/xterm key decoder
// Turns a stream of terminal bytes into dense key codes.
// ----------------------------------------------------------------------------
// One byte is taken per cycle on the input channel while the key side does not
// stall, and lands in an input register; it is then decoded against the parse
// state and, when a key is complete, loads the output register. A stalled key
// side holds the full input register and stalls the byte side. Bytes that
// continue an escape sequence give no output beat. more_pending is looked at
// only for an ESC byte outside a sequence: high starts a sequence, low reports
// Esc.
// ----------------------------------------------------------------------------
module terminal_key_sequence_decoder import tksd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  byte_in,
	input  wire logic        more_pending,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [5:0]       key_code
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       pend_s1;
	mode_t      mode_q;
	key_t       held_q;
	logic       out_valid_q;
	key_t       key_q;
	logic       advance;
	step_t      step;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign key_code  = key_q;

	tksd_decode u_decode (
		.mode         (mode_q),
		.held         (held_q),
		.byte_in      (byte_s1),
		.more_pending (pend_s1),
		.step         (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= byte_in;
			pend_s1 <= more_pending;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			held_q      <= K_UNKNOWN;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && step.emit;
			if (valid_s1) begin
				mode_q <= step.mode;
				held_q <= step.held;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && step.emit) begin
			key_q <= step.key;
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for terminal_key_sequence_decoder
// Streams plain bytes, complete escape sequences and broken ones into the
// decoder. Both sides idle and stall at random, and the key side holds off
// once for a long stretch. Every key beat is checked against a decode of the
// accepted bytes that this bench keeps on its own.
// ----------------------------------------------------------------------------
module tb_top;
	import tksd_pkg::*;

	localparam int N_ITEMS     = 2000;
	localparam int WATCHDOG    = 1000;
	localparam int DRAIN       = 20;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 200;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] b;
		logic       p;
	} term_byte_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] byte_in = 8'd0;
	logic       more_pending = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [5:0] key_code;

	term_byte_t byte_q[$];
	key_t       key_q[$];

	mode_t parse_st = MODE_IDLE;
	key_t  held_st = K_UNKNOWN;

	bit in_beat = 1'b0;
	bit out_beat = 1'b0;
	int errors = 0;
	int bytes_seen = 0;
	int keys_seen = 0;
	int seq_starts = 0;
	int stall_cycles = 0;
	int idle_cycles = 0;

	terminal_key_sequence_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_in(byte_in),
		.more_pending(more_pending),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_code(key_code)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Decode one accepted byte and queue the key it completes, if any.
	task automatic decode_byte(input logic [7:0] b, input logic p);
		key_t k;
		bit done;
		k = K_UNKNOWN;
		done = 1'b1;
		case (parse_st)
			MODE_ESC: begin
				parse_st = MODE_IDLE;
				if (b == B_UC_O) begin
					parse_st = MODE_ESC_O;
					done = 1'b0;
				end else if (b == B_LBRACK) begin
					parse_st = MODE_ESC_BR;
					done = 1'b0;
				end
			end
			MODE_ESC_O: begin
				parse_st = MODE_IDLE;
				if (b == B_UC_H) k = K_HOME;
				else if (b == B_UC_F) k = K_END;
				else if (b >= B_UC_P && b <= B_UC_S) k = K_F1 + key_t'(b - B_UC_P);
			end
			MODE_ESC_BR: begin
				parse_st = MODE_IDLE;
				case (b)
					B_TWO: begin
						held_st = K_INSERT;
						parse_st = MODE_SKIP;
						done = 1'b0;
					end
					B_THREE: begin
						held_st = K_DELETE;
						parse_st = MODE_SKIP;
						done = 1'b0;
					end
					B_FIVE: begin
						held_st = K_PGUP;
						parse_st = MODE_SKIP;
						done = 1'b0;
					end
					B_SIX: begin
						held_st = K_PGDN;
						parse_st = MODE_SKIP;
						done = 1'b0;
					end
					B_ONE: begin
						parse_st = MODE_ESC_BR1;
						done = 1'b0;
					end
					default: begin
						if (b >= B_UC_A && b <= B_UC_D) k = K_UP + key_t'(b - B_UC_A);
					end
				endcase
			end
			MODE_ESC_BR1: begin
				parse_st = MODE_IDLE;
				if (b == B_FIVE) begin
					held_st = K_F5;
					parse_st = MODE_SKIP;
					done = 1'b0;
				end else if (b >= B_SEVEN && b <= B_NINE) begin
					held_st = K_F5 + 6'd1 + key_t'(b - B_SEVEN);
					parse_st = MODE_SKIP;
					done = 1'b0;
				end
			end
			MODE_SKIP: begin
				parse_st = MODE_IDLE;
				k = held_st;
			end
			default: begin
				parse_st = MODE_IDLE;
				if (b == B_ESC) begin
					if (p) begin
						parse_st = MODE_ESC;
						seq_starts++;
						done = 1'b0;
					end else begin
						k = K_ESC;
					end
				end else begin
					case (b)
						B_LF:     k = K_ENTER;
						B_SPACE:  k = K_SPACE;
						B_TAB:    k = K_TAB;
						B_COMMA:  k = K_COMMA;
						B_PERIOD: k = K_PERIOD;
						B_DEL:    k = K_BACK;
						B_TILDE:  k = K_DELETE;
						default: begin
							if (b >= B_ZERO && b <= B_NINE)
								k = K_DIGIT0 + key_t'(b - B_ZERO);
							else if (b >= B_UC_A && b <= B_UC_Z)
								k = K_LETTER_A + key_t'(b - B_UC_A);
							else if (b >= B_LC_A && b <= B_LC_Z)
								k = K_LETTER_A + key_t'(b - B_LC_A);
						end
					endcase
				end
			end
		endcase
		if (done) key_q.push_back(k);
	endtask

	task automatic report_err(input string what, input int want, input int got);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("ERROR: %s: expected key %0d, got %0d at %0t", what, want, got, $realtime);
	endtask

	task automatic add_byte(input logic [7:0] b, input logic p);
		byte_q.push_back({b, p});
	endtask

	function automatic logic rand_bit();
		return logic'($urandom_range(0, 1));
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic add_plain();
		add_byte(rand_byte(), rand_bit());
	endtask

	task automatic add_good_seq();
		int r;
		add_byte(B_ESC, 1'b1);
		case ($urandom_range(0, 3))
			0: begin
				add_byte(B_UC_O, rand_bit());
				r = $urandom_range(0, 5);
				if (r == 0) add_byte(B_UC_H, rand_bit());
				else if (r == 1) add_byte(B_UC_F, rand_bit());
				else add_byte(B_UC_P + 8'(r - 2), rand_bit());
			end
			1: begin
				add_byte(B_LBRACK, rand_bit());
				add_byte(B_UC_A + 8'($urandom_range(0, 3)), rand_bit());
			end
			2: begin
				add_byte(B_LBRACK, rand_bit());
				case ($urandom_range(0, 3))
					0: add_byte(B_TWO, rand_bit());
					1: add_byte(B_THREE, rand_bit());
					2: add_byte(B_FIVE, rand_bit());
					default: add_byte(B_SIX, rand_bit());
				endcase
				add_byte(($urandom_range(0, 3) == 0) ? rand_byte() : B_TILDE, rand_bit());
			end
			default: begin
				add_byte(B_LBRACK, rand_bit());
				add_byte(B_ONE, rand_bit());
				r = $urandom_range(0, 3);
				add_byte((r == 0) ? B_FIVE : B_SEVEN + 8'(r - 1), rand_bit());
				add_byte(($urandom_range(0, 3) == 0) ? rand_byte() : B_TILDE, rand_bit());
			end
		endcase
	endtask

	task automatic add_broken_seq();
		add_byte(B_ESC, 1'b1);
		case ($urandom_range(0, 3))
			0: ;
			1: add_byte(B_UC_O, rand_bit());
			2: add_byte(B_LBRACK, rand_bit());
			default: begin
				add_byte(B_LBRACK, rand_bit());
				add_byte(B_ONE, rand_bit());
			end
		endcase
		add_byte(rand_byte(), rand_bit());
	endtask

	// Byte side: hold a stalled beat, otherwise wait out the drawn gap.
	int  in_gap = 0;
	bit  in_calm = 1'b0;
	always @(negedge clk) begin
		term_byte_t nxt;
		logic nv;
		if (arst_n) begin
			if (in_valid && !in_beat) begin
				nv = 1'b1;
			end else if (in_gap > 0) begin
				in_gap--;
				nv = 1'b0;
			end else if (byte_q.size() > 0) begin
				nxt = byte_q.pop_front();
				byte_in <= nxt.b;
				more_pending <= nxt.p;
				nv = 1'b1;
				if ($urandom_range(0, 99) == 0) in_calm = ~in_calm;
				in_gap = in_calm ? 0 : $urandom_range(0, 9);
			end else begin
				nv = 1'b0;
			end
			in_valid <= nv;
		end
	end

	// Key side: stall for a drawn count after each beat, plus one long hold.
	int out_wait = 0;
	int out_hold = 0;
	int out_taken = 0;
	bit out_calm = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_beat) begin
				out_taken++;
				if (out_taken == HOLD_AT) out_hold = HOLD_CYCLES;
				if ($urandom_range(0, 99) == 0) out_calm = ~out_calm;
				out_wait = out_calm ? 0 : $urandom_range(0, 9);
			end
			if (out_hold > 0) begin
				out_hold--;
				out_stall <= 1'b1;
			end else if (out_wait > 0) begin
				out_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		key_t want;
		if (arst_n) begin
			in_beat = in_valid && !in_stall;
			out_beat = out_valid && !out_stall;
			if (in_valid && in_stall) stall_cycles++;
			if (out_beat) begin
				keys_seen++;
				if (key_q.size() == 0) begin
					report_err("key beat with none pending", -1, key_code);
				end else begin
					want = key_q.pop_front();
					if (key_code !== want) report_err("key_code mismatch", want, key_code);
				end
			end
			if (in_beat) begin
				bytes_seen++;
				decode_byte(byte_in, more_pending);
			end
			if (in_beat || out_beat) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog: no beat for %0d cycles", WATCHDOG);
				$display("terminal_key_sequence_decoder test failed");
				$finish;
			end
		end
	end

	initial begin
		// directed: field extremes, several key groups and broken sequences
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b1);
		add_byte(B_LC_A, 1'b1);
		add_byte(B_UC_Z, 1'b0);
		add_byte(B_NINE, 1'b1);
		add_byte(B_DEL, 1'b0);
		add_byte(B_TILDE, 1'b1);
		add_byte(B_ESC, 1'b0);
		add_byte(B_ESC, 1'b1);
		add_byte(B_UC_O, 1'b1);
		add_byte(B_UC_S, 1'b0);
		add_byte(B_ESC, 1'b1);
		add_byte(B_UC_O, 1'b0);
		add_byte(B_LC_A + 8'd16, 1'b1);
		add_byte(B_ESC, 1'b1);
		add_byte(B_LBRACK, 1'b0);
		add_byte(B_UC_D, 1'b1);
		add_byte(B_ESC, 1'b1);
		add_byte(B_LBRACK, 1'b1);
		add_byte(B_ONE, 1'b0);
		add_byte(B_NINE, 1'b1);
		add_byte(B_ESC, 1'b0);
		add_byte(B_ESC, 1'b1);
		add_byte(B_LBRACK, 1'b1);
		add_byte(B_SIX, 1'b1);
		add_byte(8'hFF, 1'b0);
		add_byte(B_ESC, 1'b1);
		add_byte(B_LBRACK, 1'b0);
		add_byte(B_ONE, 1'b1);
		add_byte(B_TWO, 1'b0);
		add_byte(B_ESC, 1'b1);
		add_byte(B_ESC, 1'b1);
		while (byte_q.size() < N_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: add_plain();
				4, 5, 6, 7, 8: add_good_seq();
				default: add_broken_seq();
			endcase
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (byte_q.size() > 0 || in_valid) @(posedge clk);
		while (key_q.size() > 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("bytes %0d, escape sequences %0d, keys checked %0d, mismatches %0d",
			bytes_seen, seq_starts, keys_seen, errors);
		$display("byte side held off for %0d cycles", stall_cycles);
		if (errors == 0)
			$display("terminal_key_sequence_decoder test passed");
		else
			$display("terminal_key_sequence_decoder test failed");
		$finish;
	end

endmodule
